### hdl/nnrd_pkg.sv
// Package for the nearest-neighbour rectangle downscaler.
// Holds the configuration and job types, register indexes and fixed limits.
// No dependencies.
package nnrd_pkg;

    // Widest canvas or viewport for which a rectangle is accepted.
    localparam int unsigned MAX_WIDTH = 1024;

    // Divider operand widths shared by both coordinate units.
    localparam int unsigned NUM_W = 24;
    localparam int unsigned DEN_W = 12;

    // Configuration register indexes.
    localparam logic [2:0] REG_CANVAS_WIDTH   = 3'd0;
    localparam logic [2:0] REG_CANVAS_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_VIEW_WIDTH     = 3'd2;
    localparam logic [2:0] REG_VIEW_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_VIEW_LEFT      = 3'd4;
    localparam logic [2:0] REG_VIEW_TOP       = 3'd5;

    // Input item modes.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef struct packed {
        logic [10:0] canvas_width;
        logic [11:0] canvas_height;
        logic [10:0] view_width;
        logic [11:0] view_height;
        logic [9:0]  view_left;
        logic [10:0] view_top;
    } cfg_t;

    // One source pixel handed from the front part to the back part.
    typedef struct packed {
        logic [9:0]  col;
        logic [10:0] row;
        logic        page;
        logic [15:0] pixel;
    } job_t;

endpackage

### hdl/nearest_neighbour_rect_downscaler_top.sv
// Nearest-neighbour rectangle downscaler, top level.
// A start beat (mode 0) on the s_ channel sets a dirty rectangle of the
// logical canvas and its page; each following pixel beat (mode 1) carries
// one source pixel in raster order. Pixels that are the nearest-neighbour
// pick of a viewport pixel leave on the m_ channel with absolute
// coordinates; others, and rectangles off the canvas, give no beat.
// Start beats are handled by the front part alone. Each pixel beat is
// queued (four deep) and then passes through the back part in order:
// loading, forming the products, the two bit-serial dividers running side
// by side (24 quotient bits, then a hand-over) and the decision; the back
// part takes no new pixel until it is through with the last, so the
// divider length sets the sustained rate. If the receiver stalls, the
// result is held in the output register; the queue keeps taking beats
// until it fills, then s_ready drops.
// The cfg_ port writes the six geometry registers; it is always ready.
// Synchronous active-low reset restores the default 320x240 geometry, drops
// any active rectangle and empties the queue.
// Depends on nnrd_pkg, nnrd_front, nnrd_fifo, nnrd_div and nnrd_back.
module nearest_neighbour_rect_downscaler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [9:0]  s_rect_left,
    input  logic [10:0] s_rect_top,
    input  logic [9:0]  s_rect_right,
    input  logic [10:0] s_rect_bottom,
    input  logic        s_target_page,
    input  logic [15:0] s_pixel_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_dest_x,
    output logic [10:0] m_dest_y,
    output logic        m_dest_page,
    output logic [15:0] m_pixel_out
);

    nnrd_pkg::cfg_t cfg_reg;
    nnrd_pkg::job_t push_data, pop_data;
    logic q_push, q_full, q_pop, q_empty;

    assign cfg_ready = 1'b1;

    // Geometry registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.canvas_width   <= 11'd320;
            cfg_reg.canvas_height  <= 12'd240;
            cfg_reg.view_width     <= 11'd320;
            cfg_reg.view_height    <= 12'd240;
            cfg_reg.view_left      <= 10'd0;
            cfg_reg.view_top       <= 11'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                nnrd_pkg::REG_CANVAS_WIDTH:  cfg_reg.canvas_width  <= cfg_data[10:0];
                nnrd_pkg::REG_CANVAS_HEIGHT: cfg_reg.canvas_height <= cfg_data;
                nnrd_pkg::REG_VIEW_WIDTH:    cfg_reg.view_width    <= cfg_data[10:0];
                nnrd_pkg::REG_VIEW_HEIGHT:   cfg_reg.view_height   <= cfg_data;
                nnrd_pkg::REG_VIEW_LEFT:     cfg_reg.view_left     <= cfg_data[9:0];
                nnrd_pkg::REG_VIEW_TOP:      cfg_reg.view_top      <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    nnrd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_rect_left(s_rect_left), .s_rect_top(s_rect_top),
        .s_rect_right(s_rect_right), .s_rect_bottom(s_rect_bottom),
        .s_target_page(s_target_page), .s_pixel_in(s_pixel_in),
        .q_full(q_full), .q_push(q_push), .q_data(push_data)
    );

    nnrd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_data(push_data),
        .full(q_full), .pop(q_pop), .pop_data(pop_data), .empty(q_empty)
    );

    nnrd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_empty(q_empty), .q_pop(q_pop), .q_data(pop_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_dest_x(m_dest_x),
        .m_dest_y(m_dest_y), .m_dest_page(m_dest_page), .m_pixel_out(m_pixel_out)
    );

endmodule

### hdl/nnrd_fifo.sv
// Short job queue between the front and back parts of the downscaler.
// Depends on nnrd_pkg for the job type.
module nnrd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  nnrd_pkg::job_t  push_data,
    output logic            full,
    input  logic            pop,
    output nnrd_pkg::job_t  pop_data,
    output logic            empty
);

    localparam int unsigned DEPTH = 4;

    nnrd_pkg::job_t mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    assign full     = (count_reg == 3'(DEPTH));
    assign empty    = (count_reg == 3'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("job queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(DEPTH))
        else $error("job queue fill count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[1:0])
        else $error("job queue pointers disagree with fill count");

endmodule

### hdl/nnrd_front.sv
// Front part of the downscaler: accepts items, checks rectangles and
// walks the raster position, queuing one job per source pixel.
// Depends on nnrd_pkg.
module nnrd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  nnrd_pkg::cfg_t  cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_mode,
    input  logic [9:0]      s_rect_left,
    input  logic [10:0]     s_rect_top,
    input  logic [9:0]      s_rect_right,
    input  logic [10:0]     s_rect_bottom,
    input  logic            s_target_page,
    input  logic [15:0]     s_pixel_in,
    input  logic            q_full,
    output logic            q_push,
    output nnrd_pkg::job_t  q_data
);

    logic [9:0]  left_reg, right_reg;
    logic [10:0] bottom_reg;
    logic        page_reg;
    logic [9:0]  col_reg;
    logic [10:0] row_reg;
    logic        ok_reg;

    logic accept, rect_good;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // A rectangle is kept only if it lies on the canvas with its corners in order and both widths fit.
    assign rect_good = !({1'b0, s_rect_right} >= cfg.canvas_width ||
                         {1'b0, s_rect_bottom} >= cfg.canvas_height ||
                         s_rect_left > s_rect_right ||
                         s_rect_top > s_rect_bottom ||
                         cfg.canvas_width > 11'(nnrd_pkg::MAX_WIDTH) ||
                         cfg.view_width > 11'(nnrd_pkg::MAX_WIDTH));

    assign q_push       = accept && (s_mode == nnrd_pkg::MODE_PIXEL) && ok_reg;
    assign q_data.col   = col_reg;
    assign q_data.row   = row_reg;
    assign q_data.page  = page_reg;
    assign q_data.pixel = s_pixel_in;

    // Rectangle state and raster walk.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            page_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            ok_reg     <= 1'b0;
        end else if (accept) begin
            if (s_mode == nnrd_pkg::MODE_START) begin
                ok_reg <= rect_good;
                if (rect_good) begin
                    left_reg   <= s_rect_left;
                    right_reg  <= s_rect_right;
                    bottom_reg <= s_rect_bottom;
                    page_reg   <= s_target_page;
                    col_reg    <= s_rect_left;
                    row_reg    <= s_rect_top;
                end
            end else if (ok_reg) begin
                if (col_reg >= right_reg) begin
                    col_reg <= left_reg;
                    if (row_reg >= bottom_reg) begin
                        ok_reg <= 1'b0;
                    end else begin
                        row_reg <= row_reg + 11'd1;
                    end
                end else begin
                    col_reg <= col_reg + 10'd1;
                end
            end
        end
    end

endmodule

### hdl/nnrd_div.sv
// Restoring divider, one quotient bit per cycle, for the coordinate picks.
// Depends on nnrd_pkg for operand widths.
module nnrd_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [nnrd_pkg::NUM_W-1:0]        numer,
    input  logic [nnrd_pkg::DEN_W-1:0]        denom,
    output logic                              done,
    output logic [nnrd_pkg::NUM_W-1:0]        quot,
    output logic [nnrd_pkg::DEN_W-1:0]        rem
);

    localparam int unsigned NW = nnrd_pkg::NUM_W;
    localparam int unsigned DW = nnrd_pkg::DEN_W;
    localparam int unsigned CW = $clog2(NW);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;

    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          ge;

    // Bring down the next numerator bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign ge    = !diff[DW+1];

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

endmodule

### hdl/nnrd_back.sv
// Back part of the downscaler: takes queued pixels, decides whether each is
// a nearest-neighbour pick and holds kept results in the output register.
// Depends on nnrd_pkg and nnrd_div.
module nnrd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  nnrd_pkg::cfg_t  cfg,
    input  logic            q_empty,
    output logic            q_pop,
    input  nnrd_pkg::job_t  q_data,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [9:0]      m_dest_x,
    output logic [10:0]     m_dest_y,
    output logic            m_dest_page,
    output logic [15:0]     m_pixel_out
);

    localparam int unsigned NW = nnrd_pkg::NUM_W;
    localparam int unsigned DW = nnrd_pkg::DEN_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]     state_reg, state_next;
    nnrd_pkg::job_t job_reg;
    logic           m_valid_reg;
    logic [9:0]     dest_x_reg;
    logic [10:0]    dest_y_reg;
    logic           dest_page_reg;
    logic [15:0]    pixel_reg;

    logic [NW-1:0] numer_x, numer_y, quot_x, quot_y;
    logic [DW-1:0] lw, lh, vw, vh, rem_x, rem_y, gap_x, gap_y;
    logic          start, done_x, done_y, keep, out_free;

    assign lw = {1'b0, cfg.canvas_width};
    assign lh = cfg.canvas_height;
    assign vw = {1'b0, cfg.view_width};
    assign vh = cfg.view_height;

    // Numerator of the ceiling division: c * view + logical - 1.
    assign numer_x = NW'(job_reg.col) * NW'(vw) + NW'(lw) - NW'(1);
    assign numer_y = NW'(job_reg.row) * NW'(vh) + NW'(lh) - NW'(1);
    assign start   = (state_reg == ST_MUL);

    nnrd_div u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(start), .numer(numer_x),
        .denom(lw), .done(done_x), .quot(quot_x), .rem(rem_x)
    );

    nnrd_div u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(start), .numer(numer_y),
        .denom(lh), .done(done_y), .quot(quot_y), .rem(rem_y)
    );

    // The pick maps back by floor when ceil*logical - c*view is below view.
    assign gap_x = lw - DW'(1) - rem_x;
    assign gap_y = lh - DW'(1) - rem_y;
    assign keep  = (vw != '0) && (lw != '0) && (gap_x < vw) &&
                   (vh != '0) && (lh != '0) && (gap_y < vh);

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // Sequencer over one pixel.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (done_x && done_y) state_next = ST_OUT;
            ST_OUT:  if (!keep || out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && keep && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Job and result payload registers.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_data;
        end
        if (state_reg == ST_OUT && keep && out_free) begin
            dest_x_reg    <= cfg.view_left + quot_x[9:0];
            dest_y_reg    <= cfg.view_top + quot_y[10:0];
            dest_page_reg <= job_reg.page;
            pixel_reg     <= job_reg.pixel;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_dest_x    = dest_x_reg;
    assign m_dest_y    = dest_y_reg;
    assign m_dest_page = dest_page_reg;
    assign m_pixel_out = pixel_reg;

endmodule

### test/nearest_neighbour_rect_downscaler_top_tb.sv
// Self-checking testbench for nearest_neighbour_rect_downscaler_top.
// It holds its own downscaling predictor and a directed table, then runs random rectangles.
// Depends on nnrd_pkg and the RTL of the downscaler.
module nearest_neighbour_rect_downscaler_top_tb;

    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned PHASES = 12;
    localparam int unsigned ITEMS_PER_PHASE = 132;

    typedef struct {
        logic        mode;
        logic [9:0]  left;
        logic [10:0] top;
        logic [9:0]  right;
        logic [10:0] bottom;
        logic        page;
        logic [15:0] pixel;
    } beat_t;

    typedef struct {
        logic [9:0]  x;
        logic [10:0] y;
        logic        page;
        logic [15:0] pixel;
    } dest_t;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_NO_PIXEL,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        beat_t     beat;
        row_kind_t kind;
        dest_t     dest;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = nnrd_pkg::REG_CANVAS_WIDTH;
    logic [11:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = nnrd_pkg::MODE_START;
    logic [9:0]  s_rect_left = '0;
    logic [10:0] s_rect_top = '0;
    logic [9:0]  s_rect_right = '0;
    logic [10:0] s_rect_bottom = '0;
    logic        s_target_page = 1'b0;
    logic [15:0] s_pixel_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [9:0]  m_dest_x;
    logic [10:0] m_dest_y;
    logic        m_dest_page;
    logic [15:0] m_pixel_out;

    // Predictor state: geometry registers and the active rectangle.
    nnrd_pkg::cfg_t geom;
    logic [9:0]  rc_left, rc_right, col_now;
    logic [10:0] rc_top, rc_bottom, row_now;
    logic        page_now;
    logic        rect_live;

    dest_t       pending_pixels[$];
    row_t        directed[$];
    bit          failed = 1'b0;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;

    nearest_neighbour_rect_downscaler_top DUT (.*);

    always #5 aclk = ~aclk;

    // Nearest-neighbour pick on one axis: the ceil destination must map back by floor.
    function automatic bit nn_pick(input longint unsigned c, input longint unsigned view,
                                   input longint unsigned logical,
                                   output longint unsigned d);
        if (view == 0 || logical == 0) return 1'b0;
        d = (c * view + logical - 1) / logical;
        return ((d * logical) / view) == c;
    endfunction

    // Advances the rectangle state for one accepted beat; returns 1 if a pixel leaves.
    function automatic bit downscale_beat(input beat_t b, output dest_t r);
        longint unsigned dx, dy;
        logic [9:0]  col;
        logic [10:0] row;
        bit          keep;
        if (b.mode == nnrd_pkg::MODE_START) begin
            rect_live = 1'b0;
            if (b.right >= geom.canvas_width || b.bottom >= geom.canvas_height ||
                b.left > b.right || b.top > b.bottom ||
                geom.canvas_width > nnrd_pkg::MAX_WIDTH ||
                geom.view_width > nnrd_pkg::MAX_WIDTH)
                return 1'b0;
            rc_left = b.left;
            rc_top = b.top;
            rc_right = b.right;
            rc_bottom = b.bottom;
            page_now = b.page;
            col_now = b.left;
            row_now = b.top;
            rect_live = 1'b1;
            return 1'b0;
        end
        if (!rect_live) return 1'b0;
        col = col_now;
        row = row_now;
        if (col_now >= rc_right) begin
            col_now = rc_left;
            if (row_now >= rc_bottom) rect_live = 1'b0;
            else row_now = row_now + 11'd1;
        end else begin
            col_now = col_now + 10'd1;
        end
        keep = nn_pick(col, geom.view_width, geom.canvas_width, dx);
        if (keep) keep = nn_pick(row, geom.view_height, geom.canvas_height, dy);
        if (!keep) return 1'b0;
        r.x = 10'(geom.view_left + dx);
        r.y = 11'(geom.view_top + dy);
        r.page = page_now;
        r.pixel = b.pixel;
        return 1'b1;
    endfunction

    // Writes all six geometry registers, one beat each, and mirrors them.
    task automatic write_geometry(input logic [11:0] vals[6]);
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (3'(i))
                nnrd_pkg::REG_CANVAS_WIDTH:  geom.canvas_width = vals[i][10:0];
                nnrd_pkg::REG_CANVAS_HEIGHT: geom.canvas_height = vals[i];
                nnrd_pkg::REG_VIEW_WIDTH:    geom.view_width = vals[i][10:0];
                nnrd_pkg::REG_VIEW_HEIGHT:   geom.view_height = vals[i];
                nnrd_pkg::REG_VIEW_LEFT:     geom.view_left = vals[i][9:0];
                nnrd_pkg::REG_VIEW_TOP:      geom.view_top = vals[i][10:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Drives one beat, waits for acceptance and records what should leave.
    task automatic send_beat(input beat_t b, input row_kind_t kind, input dest_t typed);
        dest_t r;
        bit    has;
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= b.mode;
        s_rect_left <= b.left;
        s_rect_top <= b.top;
        s_rect_right <= b.right;
        s_rect_bottom <= b.bottom;
        s_target_page <= b.page;
        s_pixel_in <= b.pixel;
        do @(posedge aclk); while (!s_ready);
        has = downscale_beat(b, r);
        if (kind == ROW_TYPED) pending_pixels.push_back(typed);
        else if (kind == ROW_PREDICTED && has) pending_pixels.push_back(r);
    endtask

    // Waits for every expected pixel, then lets rejected pixels clear the queue.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic beat_t mk(input logic mode, input int l, input int t, input int r,
                                 input int b, input logic pg, input logic [15:0] px);
        beat_t s;
        s.mode = mode;
        s.left = 10'(l);
        s.top = 11'(t);
        s.right = 10'(r);
        s.bottom = 11'(b);
        s.page = pg;
        s.pixel = px;
        return s;
    endfunction

    function automatic void add_row(input beat_t b, input row_kind_t kind,
                                    input int x = 0, input int y = 0,
                                    input logic pg = 1'b0, input logic [15:0] px = '0);
        row_t rw;
        rw.beat = b;
        rw.kind = kind;
        rw.dest.x = 10'(x);
        rw.dest.y = 11'(y);
        rw.dest.page = pg;
        rw.dest.pixel = px;
        directed.push_back(rw);
    endfunction

    // Random rectangle content: mostly well-formed, the rest random beats or rectangles cut short or overrun.
    task automatic random_phase(input int unsigned count);
        int unsigned sent, cw, ch, w, h, l, t, n;
        dest_t       none;
        none = '{default: '0};
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                send_beat(mk($urandom_range(1), $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(1), 16'($urandom)), ROW_PREDICTED, none);
                sent++;
            end else begin
                cw = (geom.canvas_width == 0) ? 1 :
                     (geom.canvas_width > 1024 ? 1024 : geom.canvas_width);
                ch = (geom.canvas_height == 0) ? 1 :
                     (geom.canvas_height > 2048 ? 2048 : geom.canvas_height);
                w = $urandom_range(cw < 8 ? cw : 8, 1);
                h = $urandom_range(ch < 6 ? ch : 6, 1);
                l = $urandom_range(cw - w);
                t = $urandom_range(ch - h);
                send_beat(mk(nnrd_pkg::MODE_START, l, t, l + w - 1, t + h - 1,
                             $urandom_range(1), 16'($urandom)), ROW_PREDICTED, none);
                n = w * h;
                if ($urandom_range(7) == 0) n = $urandom_range(n + 3);
                for (int i = 0; i < n; i++)
                    send_beat(mk(nnrd_pkg::MODE_PIXEL, $urandom, $urandom, $urandom,
                                 $urandom, $urandom_range(1), 16'($urandom)),
                              ROW_PREDICTED, none);
                sent += n + 1;
            end
        end
    endtask

    // Receiver stalls.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Compares each result beat with the oldest expected pixel.
    always @(posedge aclk) begin
        dest_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result beat x=%0d y=%0d", m_dest_x, m_dest_y);
                failed = 1'b1;
            end else begin
                e = pending_pixels.pop_front();
                if (m_dest_x !== e.x) begin
                    $error("dest_x expected %0d got %0d", e.x, m_dest_x);
                    failed = 1'b1;
                end
                if (m_dest_y !== e.y) begin
                    $error("dest_y expected %0d got %0d", e.y, m_dest_y);
                    failed = 1'b1;
                end
                if (m_dest_page !== e.page) begin
                    $error("dest_page expected %0d got %0d", e.page, m_dest_page);
                    failed = 1'b1;
                end
                if (m_pixel_out !== e.pixel) begin
                    $error("pixel_out expected %h got %h", e.pixel, m_pixel_out);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("nearest_neighbour_rect_downscaler_top_tb NOT OK");
        $finish;
    end

    initial begin
        logic [11:0] vals[6];
        int unsigned lw, lh;
        geom = '{canvas_width: 11'd320, canvas_height: 12'd240, view_width: 11'd320,
                 view_height: 12'd240, view_left: '0, view_top: '0};
        rect_live = 1'b0;
        rc_left = '0; rc_right = '0; rc_top = '0; rc_bottom = '0;
        col_now = '0; row_now = '0; page_now = 1'b0;

        // Directed rows at the reset geometry, where the mapping is the identity.
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h1234), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_START, 0, 0, 1, 1, 1, 16'h0), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h0000), ROW_TYPED,
                0, 0, 1, 16'h0000);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'hFFFF), ROW_TYPED,
                1, 0, 1, 16'hFFFF);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'hAAAA), ROW_TYPED,
                0, 1, 1, 16'hAAAA);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h5555), ROW_TYPED,
                1, 1, 1, 16'h5555);
        // Rectangle complete: further pixels are ignored.
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h0F0F), ROW_NO_PIXEL);
        // Rectangle off the canvas to the right, then below.
        add_row(mk(nnrd_pkg::MODE_START, 0, 0, 320, 0, 0, 16'h0), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h1111), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_START, 0, 0, 0, 240, 0, 16'h0), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h2222), ROW_NO_PIXEL);
        // Reversed corners.
        add_row(mk(nnrd_pkg::MODE_START, 5, 0, 4, 0, 0, 16'h0), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h3333), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_START, 0, 9, 0, 8, 0, 16'h0), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h4444), ROW_NO_PIXEL);
        // Far corner of the canvas, and all-ones corners.
        add_row(mk(nnrd_pkg::MODE_START, 319, 239, 319, 239, 0, 16'h0), ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 1023, 2047, 1023, 2047, 1, 16'hFFFF), ROW_TYPED,
                319, 239, 0, 16'hFFFF);
        add_row(mk(nnrd_pkg::MODE_START, 1023, 2047, 1023, 2047, 1, 16'hFFFF),
                ROW_NO_PIXEL);
        add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'h6666), ROW_NO_PIXEL);
        // A strip at the right edge of the canvas, cut short, left to the predictor.
        add_row(mk(nnrd_pkg::MODE_START, 316, 100, 319, 101, 1, 16'h0), ROW_PREDICTED);
        for (int i = 0; i < 5; i++)
            add_row(mk(nnrd_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 16'(i * 16'h1357)),
                    ROW_PREDICTED);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_beat(directed[i].beat, directed[i].kind, directed[i].dest);
        drain();

        // Random phases over several geometries, idling pattern by third of the run.
        for (int p = 0; p < PHASES; p++) begin
            case (p / 4)
                0: begin send_idle = 30; recv_idle = 77; end
                1: begin send_idle = 77; recv_idle = 30; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            lw = $urandom_range(48, 1);
            lh = $urandom_range(48, 1);
            vals[0] = 12'(lw);
            vals[1] = 12'(lh);
            vals[2] = 12'($urandom_range(lw, 1));
            vals[3] = 12'($urandom_range(lh, 1));
            vals[4] = 12'($urandom_range(1023));
            vals[5] = 12'($urandom_range(2047));
            case (p % 4)
                1: begin
                    // Upscale: viewport larger than the canvas.
                    lw = $urandom_range(24, 1);
                    lh = $urandom_range(24, 1);
                    vals[0] = 12'(lw);
                    vals[1] = 12'(lh);
                    vals[2] = 12'($urandom_range(1024, lw + 1));
                    vals[3] = 12'($urandom_range(2047, lh + 1));
                end
                2: begin
                    if (p == 6) vals = '{12'd1, 12'd1, 12'd1, 12'd1, 12'd0, 12'd0};
                    else vals = '{12'd1024, 12'd2048, 12'd1024, 12'd2048, 12'd1023, 12'd2047};
                    if (p == 10) begin
                        vals[2] = 12'd17;
                        vals[3] = 12'd13;
                    end
                end
                3: begin
                    // Zero sizes and canvases or viewports too wide.
                    if (p == 3) begin
                        vals[2] = 12'd0;
                        vals[3] = 12'hFFF;
                    end else if (p == 7) begin
                        vals[0] = 12'd1500;
                        vals[2] = 12'hFFF;
                    end else begin
                        vals[1] = 12'd0;
                        vals[3] = 12'd0;
                    end
                end
                default: ;
            endcase
            write_geometry(vals);
            random_phase(ITEMS_PER_PHASE);
            drain();
        end

        if (!failed && pending_pixels.size() == 0) begin
            $display("nearest_neighbour_rect_downscaler_top_tb OK");
        end else begin
            $display("nearest_neighbour_rect_downscaler_top_tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/nnrd_pkg.sv
hdl/nnrd_fifo.sv
hdl/nnrd_front.sv
hdl/nnrd_div.sv
hdl/nnrd_back.sv
hdl/nearest_neighbour_rect_downscaler_top.sv
test/nearest_neighbour_rect_downscaler_top_tb.sv
